// File: sv/olid_pkg.sv
package olid_pkg;

   localparam int OLID_DEPTH = 16;
   localparam int VALUE_W    = 32;
   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DUMP_FWD = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DUMP_BWD = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

// File: sv/olid_ram.sv
module olid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ordered_list_insert_delete_top.sv
// Ordered table of up to DEPTH signed 32-bit values held in one RAM and walked by a
// small sequencer around a single 33-bit subtractor (signed >= and == compare).
// One request at a time. Ordered insert and delete walk the whole table (insert ripples
// the following entries up and delete pulls them down), and a dump returns one result
// per entry. With the single RAM read port and its registered read, each entry scanned
// or returned takes a read step (S_RD) and then a compare step (S_CMP). A full table
// rejects append and insert with status full, delete of a missing value gives not
// found, and a dump of an empty table gives one empty result. The result register lets
// the next request in while the last result waits.
module ordered_list_insert_delete_top
   import olid_pkg::*;
#(
   parameter int DEPTH = OLID_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  value_type           req_item_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output value_type           rsp_entry_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_entry_count,
   output logic                rsp_last_result
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   value_type           val_ff, val_in;
   value_type           carry_ff, carry_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;

   logic                rsp_valid_ff, rsp_valid_in;
   value_type           rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   value_type           wr_data;
   value_type           rd_data;

   logic [VALUE_W:0]    diff;
   logic                cmp_ge, cmp_eq;
   logic                slot_free, full, at_last_fwd, at_last_bwd, dump_last;

   olid_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // shared compare unit: sign-extended subtract
   assign diff   = {rd_data[VALUE_W-1], rd_data} - {val_ff[VALUE_W-1], val_ff};
   assign cmp_ge = ~diff[VALUE_W];
   assign cmp_eq = (diff == '0);

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign full        = (count_ff == CW'(DEPTH));
   assign at_last_fwd = (CW'(idx_ff) == count_ff - CW'(1));
   assign at_last_bwd = (idx_ff == '0);
   assign dump_last   = (mode_ff == MODE_DUMP_BWD) ? at_last_bwd : at_last_fwd;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      val_in        = val_ff;
      carry_in      = carry_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = carry_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               val_in   = req_item_value;
               found_in = 1'b0;
               idx_in   = '0;
               stat_in  = ST_OK;
               case (req_mode)
                  MODE_APPEND: begin
                     if (full) begin
                        stat_in  = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  MODE_INSERT: begin
                     if (full) begin
                        stat_in  = ST_FULL;
                        state_in = S_RESP;
                     end else if (count_ff == '0) begin
                        state_in = S_FIN;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  MODE_DELETE: begin
                     state_in = (count_ff == '0) ? S_FIN : S_RD;
                  end
                  MODE_DUMP_FWD, MODE_DUMP_BWD: begin
                     if (count_ff == '0) begin
                        stat_in  = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        if (req_mode == MODE_DUMP_BWD) begin
                           idx_in = AW'(count_ff - CW'(1));
                        end
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            case (mode_ff)
               MODE_INSERT: begin
                  // once the slot is found every later entry ripples up by one
                  if (found_ff || cmp_ge) begin
                     wr_en    = 1'b1;
                     wr_data  = found_ff ? carry_ff : val_ff;
                     carry_in = rd_data;
                     found_in = 1'b1;
                  end
                  idx_in   = idx_ff + AW'(1);
                  state_in = at_last_fwd ? S_FIN : S_RD;
               end
               MODE_DELETE: begin
                  if (found_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = idx_ff - AW'(1);
                     wr_data = rd_data;
                  end else if (cmp_eq) begin
                     found_in = 1'b1;
                  end
                  idx_in   = idx_ff + AW'(1);
                  state_in = at_last_fwd ? S_FIN : S_RD;
               end
               default: begin
                  // dumps: one result per entry, held while the output is stalled
                  if (slot_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = rd_data;
                     rsp_status_in = ST_OK;
                     rsp_count_in  = COUNT_W'(count_ff);
                     rsp_last_in   = dump_last;
                     if (dump_last) begin
                        state_in = S_IDLE;
                     end else begin
                        idx_in   = (mode_ff == MODE_DUMP_BWD) ? idx_ff - AW'(1)
                                                              : idx_ff + AW'(1);
                        state_in = S_RD;
                     end
                  end
               end
            endcase
         end
         S_FIN: begin
            if (mode_ff == MODE_DELETE) begin
               if (found_ff) begin
                  count_in = count_ff - CW'(1);
                  stat_in  = ST_OK;
               end else begin
                  stat_in  = ST_NOT_FOUND;
               end
            end else begin
               // append, or the tail write of an insert
               wr_en    = 1'b1;
               wr_addr  = AW'(count_ff);
               wr_data  = found_ff ? carry_ff : val_ff;
               count_in = count_ff + CW'(1);
               stat_in  = ST_OK;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = stat_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      val_ff        <= val_in;
      carry_ff      <= carry_in;
      idx_ff        <= idx_in;
      stat_ff       <= stat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last_result = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a request is in progress");

   a_count_only_at_fin: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(state_ff) == S_FIN)
      else $error("entry count changed outside the finish step");

   a_mid_dump_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> rsp_status == ST_OK)
      else $error("non-final result carries an error status");

   a_no_write_on_dump: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (mode_ff == MODE_APPEND || mode_ff == MODE_INSERT ||
                 mode_ff == MODE_DELETE))
      else $error("table written during a dump");
`endif

endmodule
